// ===== src/tat_pkg.sv =====
// ----------------------------------------------------------------------------
// Tick alarm table package
// Shared types and codes for the front end, the back end and the queues.
// ----------------------------------------------------------------------------
package tat_pkg;

  localparam int unsigned TickW = 32;
  localparam int unsigned SlotW = 4;
  localparam int unsigned SlotLimit = 16;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_ARM,
    CMD_CANCEL
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [SlotW-1:0]  slot;
    logic [TickW-1:0]  timeout;
  } cmd_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             last;
  } res_t;

endpackage

// ===== src/tick_alarm_table_top.sv =====
// ----------------------------------------------------------------------------
// Tick alarm table
// A 32-bit tick counter with a table of alarm slots. Set requests arm or
// cancel a slot; tick requests advance the counter and report every slot
// whose deadline matches the new count, in ascending slot order, with the
// last report of each tick marked. The back end executes a set request as
// it pops it. A tick scans min(ALARM_SLOTS, 16) slots, one slot deadline
// per cycle unless a hit meets a full result queue, then flushes the last
// report. Two command entries and two result entries buffer the two sides.
// Writing start_tick loads the counter and disarms every slot.
// ----------------------------------------------------------------------------
module tick_alarm_table_top #(
  parameter int unsigned ALARM_SLOTS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_tick_we_i,
  input  logic [tat_pkg::TickW-1:0] start_tick_i,
  input  logic                      push,
  output logic                      full,
  input  logic                      req_type_i,
  input  logic [tat_pkg::SlotW-1:0] alarm_slot_i,
  input  logic [tat_pkg::TickW-1:0] timeout_i,
  input  logic                      has_handler_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [tat_pkg::SlotW-1:0] fired_slot_o,
  output logic                      last_of_run_o
);

  import tat_pkg::*;

  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  tat_front #(
    .ALARM_SLOTS (ALARM_SLOTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .alarm_slot_i  (alarm_slot_i),
    .timeout_i     (timeout_i),
    .has_handler_i (has_handler_i),
    .cmd_pop_i     (cmd_pop),
    .cmd_o         (cmd),
    .cmd_empty_o   (cmd_empty)
  );

  tat_back #(
    .ALARM_SLOTS (ALARM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (start_tick_we_i),
    .cfg_tick_i  (start_tick_i),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  tat_fifo #(
    .DEPTH (2),
    .T     (res_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign fired_slot_o  = res_out.slot;
  assign last_of_run_o = res_out.last;

endmodule

// ===== src/tat_fifo.sv =====
// ----------------------------------------------------------------------------
// Tick alarm table queue
// Small synchronous first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module tat_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = PtrW + 1;
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  T                mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DepthC);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/tat_front.sv =====
// ----------------------------------------------------------------------------
// Tick alarm table front end
// Accepts requests, classifies them into tick, arm and cancel commands and
// queues them for the back end. Set requests to absent slots are dropped.
// ----------------------------------------------------------------------------
module tat_front #(
  parameter int unsigned ALARM_SLOTS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic                      req_type_i,
  input  logic [tat_pkg::SlotW-1:0] alarm_slot_i,
  input  logic [tat_pkg::TickW-1:0] timeout_i,
  input  logic                      has_handler_i,
  input  logic                      cmd_pop_i,
  output tat_pkg::cmd_t             cmd_o,
  output logic                      cmd_empty_o
);

  import tat_pkg::*;

  localparam int unsigned NumScan = (ALARM_SLOTS < SlotLimit) ? ALARM_SLOTS : SlotLimit;

  cmd_t cmd;
  logic keep;
  logic in_range;

  assign in_range = ({1'b0, alarm_slot_i} < (SlotW + 1)'(NumScan));

  always_comb begin
    cmd.slot    = alarm_slot_i;
    cmd.timeout = timeout_i;
    keep        = 1'b1;
    if (req_type_i == REQ_TICK) begin
      cmd.kind = CMD_TICK;
    end else if ((timeout_i != '0) && has_handler_i) begin
      cmd.kind = CMD_ARM;
      keep     = in_range;
    end else begin
      cmd.kind = CMD_CANCEL;
      keep     = in_range;
    end
  end

  tat_fifo #(
    .DEPTH (2),
    .T     (cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep),
    .data_i  (cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

// ===== src/tat_back.sv =====
// ----------------------------------------------------------------------------
// Tick alarm table back end
// Holds the tick counter and the slot table and executes commands. A tick
// scans one slot per cycle for expiries unless a hit meets a full queue.
// ----------------------------------------------------------------------------
module tat_back #(
  parameter int unsigned ALARM_SLOTS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tat_pkg::TickW-1:0] cfg_tick_i,
  input  tat_pkg::cmd_t             cmd_i,
  input  logic                      cmd_empty_i,
  output logic                      cmd_pop_o,
  output logic                      res_push_o,
  output tat_pkg::res_t             res_o,
  input  logic                      res_full_i
);

  import tat_pkg::*;

  localparam int unsigned NumScan = (ALARM_SLOTS < SlotLimit) ? ALARM_SLOTS : SlotLimit;
  localparam int unsigned IdxW = (NumScan > 1) ? $clog2(NumScan) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumScan - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e             state_q;
  logic [TickW-1:0]   tick_q;
  logic [NumScan-1:0] armed_q;
  logic [TickW-1:0]   deadline_q [NumScan];
  logic [IdxW-1:0]    idx_q;
  logic [IdxW-1:0]    cmd_idx;
  logic [IdxW-1:0]    pend_idx_q;
  logic               pend_v_q;
  logic               hit;
  logic               stall;
  logic               arm_we;

  assign cmd_idx   = cmd_i.slot[IdxW-1:0];
  assign hit       = armed_q[idx_q] && (deadline_q[idx_q] == tick_q);
  assign stall     = hit && pend_v_q && res_full_i;
  assign cmd_pop_o = (state_q == ST_IDLE) && !cmd_empty_i;
  assign arm_we    = cmd_pop_o && (cmd_i.kind == CMD_ARM);

  always_comb begin
    res_push_o = 1'b0;
    res_o.slot = SlotW'(pend_idx_q);
    res_o.last = (state_q == ST_FLUSH);
    unique case (state_q)
      ST_SCAN:  res_push_o = hit && pend_v_q && !res_full_i;
      ST_FLUSH: res_push_o = pend_v_q && !res_full_i;
      default:  res_push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tick_q     <= '0;
      armed_q    <= '0;
      idx_q      <= '0;
      pend_idx_q <= '0;
      pend_v_q   <= 1'b0;
    end else if (cfg_we_i) begin
      tick_q  <= cfg_tick_i;
      armed_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            unique case (cmd_i.kind)
              CMD_TICK: begin
                tick_q  <= tick_q + 1'b1;
                idx_q   <= '0;
                state_q <= ST_SCAN;
              end
              CMD_ARM:    armed_q[cmd_idx] <= 1'b1;
              CMD_CANCEL: armed_q[cmd_idx] <= 1'b0;
              default:    armed_q <= armed_q;
            endcase
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            if (hit) begin
              armed_q[idx_q] <= 1'b0;
              pend_idx_q     <= idx_q;
              pend_v_q       <= 1'b1;
            end
            if (idx_q == LastIdx) begin
              state_q <= ST_FLUSH;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (!res_full_i) begin
            pend_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (arm_we) begin
      deadline_q[cmd_idx] <= tick_q + cmd_i.timeout;
    end
  end

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_push_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (pend_v_q && (state_q == ST_SCAN || state_q == ST_FLUSH)))
    else $error("result pushed outside a tick scan");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last && !cfg_we_i) |=> (state_q == ST_IDLE && !pend_v_q))
    else $error("scan did not end after the last result");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending result left over in idle");
`endif

endmodule

// ===== verif/tick_alarm_table_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick alarm table testbench
// Drives set and tick requests into the alarm table under several start_tick
// settings and idle patterns, predicts every expiry in a scoreboard and
// checks each popped transaction against the oldest predicted expiry.
// ----------------------------------------------------------------------------
module tick_alarm_table_top_tb;
  import tat_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam int SettleCycles = 80;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems = 26;

  class alarm_tracker #(int unsigned SLOTS = 16);
    logic [TickW-1:0] tick_now;
    bit               armed [SLOTS];
    logic [TickW-1:0] deadline [SLOTS];
    res_t             expiry_q [$];
    int               mismatches;
    int               expiries;
    int               ticks;
    int               sets;
    int               reloads;

    function new();
      tick_now = '0;
      foreach (armed[i]) armed[i] = 1'b0;
      mismatches = 0;
      expiries = 0;
      ticks = 0;
      sets = 0;
      reloads = 0;
    endfunction

    function void load_start(logic [TickW-1:0] value);
      tick_now = value;
      foreach (armed[i]) armed[i] = 1'b0;
      reloads++;
    endfunction

    function int pending();
      return expiry_q.size();
    endfunction

    function void note_request(logic req, logic [SlotW-1:0] slot, logic [TickW-1:0] tmo,
                               logic hnd);
      int   i;
      int   fired;
      res_t hit;
      fired = 0;
      if (req == REQ_SET) begin
        sets++;
        if (slot < SLOTS) begin
          armed[slot] = 1'b0;
          if (tmo != '0 && hnd) begin
            deadline[slot] = tick_now + tmo;
            armed[slot] = 1'b1;
          end
        end
      end else begin
        ticks++;
        tick_now = tick_now + 1'b1;
        for (i = 0; i < SLOTS && i < SlotLimit; i++) begin
          if (armed[i] && deadline[i] == tick_now) begin
            armed[i] = 1'b0;
            hit.slot = i[SlotW-1:0];
            hit.last = 1'b0;
            expiry_q.push_back(hit);
            fired++;
          end
        end
        if (fired > 0) expiry_q[expiry_q.size()-1].last = 1'b1;
      end
    endfunction

    task report(string msg);
      $display("%0t ns MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_expiry(logic [SlotW-1:0] slot, logic last);
      res_t want;
      if (expiry_q.size() == 0) begin
        report($sformatf("unexpected expiry of slot %0d (last %0b)", slot, last));
      end else begin
        want = expiry_q.pop_front();
        expiries++;
        if (slot !== want.slot)
          report($sformatf("fired_slot %0d, predicted %0d", slot, want.slot));
        if (last !== want.last)
          report($sformatf("last_of_run %0b on slot %0d, predicted %0b", last, slot,
                           want.last));
      end
    endtask
  endclass

  typedef alarm_tracker #(NumSlots) tracker_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_tick_we_i = 1'b0;
  logic [TickW-1:0]   start_tick_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic               req_type_i = REQ_TICK;
  logic [SlotW-1:0]   alarm_slot_i = '0;
  logic [TickW-1:0]   timeout_i = '0;
  logic               has_handler_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [SlotW-1:0]   fired_slot_o;
  logic               last_of_run_o;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int idle_cycles = 0;
  int sent_items = 0;

  tracker_t tracker = new();

  tick_alarm_table_top #(
    .ALARM_SLOTS(NumSlots)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_tick_we_i(start_tick_we_i),
    .start_tick_i   (start_tick_i),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .alarm_slot_i   (alarm_slot_i),
    .timeout_i      (timeout_i),
    .has_handler_i  (has_handler_i),
    .empty          (empty),
    .pop            (pop),
    .fired_slot_o   (fired_slot_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) tracker.check_expiry(fired_slot_o, last_of_run_o);
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task send_request(input logic req, input logic [SlotW-1:0] slot,
                    input logic [TickW-1:0] tmo, input logic hnd);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    req_type_i    <= req;
    alarm_slot_i  <= slot;
    timeout_i     <= tmo;
    has_handler_i <= hnd;
    do @(posedge clk_i); while (full);
    tracker.note_request(req, slot, tmo, hnd);
    sent_items++;
  endtask

  task send_tick();
    send_request(REQ_TICK, SlotW'($urandom_range(15)), $urandom, 1'($urandom_range(1)));
  endtask

  task write_start(input logic [TickW-1:0] value);
    start_tick_we_i <= 1'b1;
    start_tick_i    <= value;
    @(posedge clk_i);
    tracker.load_start(value);
    start_tick_we_i <= 1'b0;
  endtask

  task drain_expiries();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task settle();
    drain_expiries();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int               p;
    int               s;
    int               n;
    int               pick;
    int               first_item;
    bit               paused;
    bit               burst_done;
    logic [SlotW-1:0] last_slot;
    logic [TickW-1:0] tmo;
    logic [TickW-1:0] start_value;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: cancels, ties, counter wrap and reloads.
    write_start(32'h0000_0000);
    send_tick();
    send_request(REQ_SET, 4'd0, 32'd1, 1'b1);
    send_request(REQ_SET, 4'd15, 32'd1, 1'b1);
    send_request(REQ_SET, 4'd3, 32'd1, 1'b1);
    send_request(REQ_SET, 4'd5, 32'd1, 1'b0);
    send_request(REQ_SET, 4'd6, 32'd0, 1'b1);
    send_request(REQ_SET, 4'd7, 32'd2, 1'b1);
    send_request(REQ_SET, 4'd7, 32'd0, 1'b0);
    send_request(REQ_SET, 4'd10, 32'hFFFF_FFFF, 1'b1);
    send_tick();
    send_tick();

    settle();
    write_start(32'hFFFF_FFFE);
    send_request(REQ_SET, 4'd1, 32'd3, 1'b1);
    send_request(REQ_SET, 4'd2, 32'd2, 1'b1);
    send_request(REQ_SET, 4'd11, 32'd5, 1'b1);
    send_request(REQ_SET, 4'd11, 32'd1, 1'b1);
    send_tick();
    send_tick();
    send_tick();
    // This deadline would match the first tick after the next reload.
    send_request(REQ_SET, 4'd10, 32'hFFFF_FFFF, 1'b1);

    settle();
    write_start(32'hFFFF_FFFF);
    send_tick();
    send_request(REQ_SET, 4'd4, 32'd1, 1'b1);
    send_tick();

    for (p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
          start_value = $urandom;
        end
        1: begin
          send_idle_pct = 82;
          pop_stall_pct = 0;
          start_value = 32'hFFFF_FFFD;
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 82;
          start_value = 32'hFFFF_FFF0;
        end
        default: begin
          send_idle_pct = 38;
          pop_stall_pct = 38;
          start_value = $urandom;
        end
      endcase
      write_start(start_value);
      first_item = sent_items;
      paused = 1'b0;
      burst_done = (p != 2);
      last_slot = '0;
      while (sent_items - first_item < PhaseItems) begin
        if (!paused && sent_items - first_item >= PhaseItems / 2) begin
          drain_expiries();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (!burst_done) begin
          // Every slot expires on the same tick.
          tmo = $urandom_range(1, 3);
          for (s = 0; s < NumSlots; s++) send_request(REQ_SET, s[SlotW-1:0], tmo, 1'b1);
          repeat (tmo) send_tick();
          burst_done = 1'b1;
        end else if (pick < 70) begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            last_slot = SlotW'($urandom_range(15));
            send_request(REQ_SET, last_slot, $urandom_range(1, 5), 1'b1);
          end
          if ($urandom_range(3) == 0) begin
            if ($urandom_range(1) == 0) begin
              send_request(REQ_SET, last_slot, 32'd0, 1'b1);
            end else begin
              send_request(REQ_SET, last_slot, $urandom_range(1, 5), 1'b0);
            end
          end
          n = $urandom_range(1, 6);
          repeat (n) send_tick();
        end else if (pick < 85) begin
          send_request(REQ_SET, SlotW'($urandom_range(15)), $urandom,
                       1'($urandom_range(1)));
        end else begin
          send_tick();
        end
      end
    end

    settle();
    $display("Sent %0d requests (%0d ticks, %0d set requests) across %0d start_tick loads.",
             sent_items, tracker.ticks, tracker.sets, tracker.reloads);
    $display("Checked %0d expiry transactions with %0d mismatches.",
             tracker.expiries, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
